// ===== rtl/two_window_interlock_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-window interlock controller
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef TWO_WINDOW_INTERLOCK_CONTROLLER_UNIT_DEFINES_SVH
`define TWO_WINDOW_INTERLOCK_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication
`define TWIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TWIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/twic_pkg.sv =====
// ----------------------------------------------------------------------------
// twic_pkg
// Types and constants shared by the interlock controller modules.
// ----------------------------------------------------------------------------
package twic_pkg;

  // Config port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Register widths
  localparam int unsigned LOCK_W   = 16;
  localparam int unsigned REGEN_W  = 19;
  localparam int unsigned DEB_W    = 10;
  localparam int unsigned BLINK_W  = 16;
  localparam int unsigned POLL_W   = 8;
  localparam int unsigned AGE_W    = 11;
  localparam int unsigned TIMER_W  = 19;

  // Accepted register ranges
  localparam logic [CFG_DATA_W-1:0] LOCK_MIN  = 32'd200;
  localparam logic [CFG_DATA_W-1:0] LOCK_MAX  = 32'd60000;
  localparam logic [CFG_DATA_W-1:0] REGEN_MAX = 32'd300000;
  localparam logic [CFG_DATA_W-1:0] DEB_MIN   = 32'd5;
  localparam logic [CFG_DATA_W-1:0] DEB_MAX   = 32'd1000;
  localparam logic [CFG_DATA_W-1:0] BLINK_MIN = 32'd1;
  localparam logic [CFG_DATA_W-1:0] BLINK_MAX = 32'd65535;
  localparam logic [CFG_DATA_W-1:0] POLL_MIN  = 32'd1;
  localparam logic [CFG_DATA_W-1:0] POLL_MAX  = 32'd255;

  // Reset values
  localparam logic [LOCK_W-1:0]  LOCK_RST  = 16'd5000;
  localparam logic [REGEN_W-1:0] REGEN_RST = 19'd10000;
  localparam logic [DEB_W-1:0]   DEB_RST   = 10'd50;
  localparam logic [BLINK_W-1:0] BLINK_RST = 16'd500;
  localparam logic [POLL_W-1:0]  POLL_RST  = 8'd10;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOCK_RELEASE = 3'd0,
    REG_REGEN        = 3'd1,
    REG_DEBOUNCE     = 3'd2,
    REG_BLINK        = 3'd3,
    REG_POLL         = 3'd4,
    REG_ACTIVE_LOW   = 3'd5,
    REG_BUZZER_EN    = 3'd6
  } cfg_reg_e;

  // Phases
  typedef enum logic [2:0] {
    PH_READY    = 3'd0,
    PH_UNLOCKED = 3'd1,
    PH_OPEN     = 3'd2,
    PH_REGEN    = 3'd3,
    PH_ALARM    = 3'd4
  } phase_e;

  // Window selection
  typedef enum logic [1:0] {
    WIN_VACANT = 2'd0,
    WIN_ONE    = 2'd1,
    WIN_TWO    = 2'd2
  } win_e;

  typedef struct packed {
    logic [LOCK_W-1:0]  lock_release_ms;
    logic [REGEN_W-1:0] regen_ms;
    logic [DEB_W-1:0]   debounce_ms;
    logic [BLINK_W-1:0] blink_half_ms;
    logic [POLL_W-1:0]  poll_step_ms;
    logic               inputs_active_low;
    logic               buzzer_enable;
  } cfg_t;

  // Debounced conditions for the current poll
  typedef struct packed {
    logic closed_one;
    logic closed_two;
    logic edge_one;
    logic edge_two;
    logic blink;
  } cond_t;

  // Lock, lamp and buzzer drive
  typedef struct packed {
    logic lock_one;
    logic lock_two;
    logic green_one;
    logic red_one;
    logic green_two;
    logic red_two;
    logic buzzer;
  } drive_t;

  localparam drive_t DRIVE_RST = '{lock_one: 1'b1, lock_two: 1'b1, default: 1'b0};

  // One result word
  typedef struct packed {
    phase_e             phase;
    win_e               active;
    drive_t             drive;
    logic               closed_one;
    logic               closed_two;
    logic [TIMER_W-1:0] elapsed;
  } result_t;

endpackage

// ===== rtl/twic_cfg.sv =====
// ----------------------------------------------------------------------------
// twic_cfg
// Timing and option registers with range check on write.
// ----------------------------------------------------------------------------
module twic_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [twic_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [twic_pkg::CFG_DATA_W-1:0]    wr_data,
  output twic_pkg::cfg_t                     cfg
);

  twic_pkg::cfg_t cfg_next;

  // Range-checked write; out-of-range data leaves the register alone
  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      case (twic_pkg::cfg_reg_e'(wr_index))
        twic_pkg::REG_LOCK_RELEASE: begin
          if (wr_data >= twic_pkg::LOCK_MIN && wr_data <= twic_pkg::LOCK_MAX)
            cfg_next.lock_release_ms = wr_data[twic_pkg::LOCK_W-1:0];
        end
        twic_pkg::REG_REGEN: begin
          if (wr_data <= twic_pkg::REGEN_MAX)
            cfg_next.regen_ms = wr_data[twic_pkg::REGEN_W-1:0];
        end
        twic_pkg::REG_DEBOUNCE: begin
          if (wr_data >= twic_pkg::DEB_MIN && wr_data <= twic_pkg::DEB_MAX)
            cfg_next.debounce_ms = wr_data[twic_pkg::DEB_W-1:0];
        end
        twic_pkg::REG_BLINK: begin
          if (wr_data >= twic_pkg::BLINK_MIN && wr_data <= twic_pkg::BLINK_MAX)
            cfg_next.blink_half_ms = wr_data[twic_pkg::BLINK_W-1:0];
        end
        twic_pkg::REG_POLL: begin
          if (wr_data >= twic_pkg::POLL_MIN && wr_data <= twic_pkg::POLL_MAX)
            cfg_next.poll_step_ms = wr_data[twic_pkg::POLL_W-1:0];
        end
        twic_pkg::REG_ACTIVE_LOW: begin
          cfg_next.inputs_active_low = wr_data[0];
        end
        twic_pkg::REG_BUZZER_EN: begin
          cfg_next.buzzer_enable = wr_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lock_release_ms   <= twic_pkg::LOCK_RST;
      cfg.regen_ms          <= twic_pkg::REGEN_RST;
      cfg.debounce_ms       <= twic_pkg::DEB_RST;
      cfg.blink_half_ms     <= twic_pkg::BLINK_RST;
      cfg.poll_step_ms      <= twic_pkg::POLL_RST;
      cfg.inputs_active_low <= 1'b1;
      cfg.buzzer_enable     <= 1'b1;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== rtl/twic_debounce.sv =====
// ----------------------------------------------------------------------------
// twic_debounce
// Four input debouncers, button edge detect and the blink generator.
// ----------------------------------------------------------------------------
module twic_debounce (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  twic_pkg::cfg_t cfg,
  input  logic [3:0]     raw,
  output twic_pkg::cond_t cond
);

  localparam int unsigned AW = twic_pkg::AGE_W;
  localparam int unsigned BW = twic_pkg::BLINK_W;

  logic [3:0]          stable, stable_next;
  logic [3:0]          last_raw, last_raw_next;
  logic [AW-1:0]       age [4];
  logic [AW-1:0]       age_next [4];
  logic [AW-1:0]       age_eff [4];
  logic [AW:0]         age_sum [4];
  logic [1:0]          button_prev, button_prev_next;
  logic                blink_state, blink_state_next;
  logic [BW-1:0]       blink_timer, blink_timer_next;
  logic [BW-1:0]       blink_eff;
  logic [BW:0]         blink_sum;
  logic                blink_wrap;

  // Per-input debounce: restart age on a level change, accept once held
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      last_raw_next[i] = raw[i] ^ cfg.inputs_active_low;
      age_eff[i]       = (last_raw_next[i] != last_raw[i]) ? '0 : age[i];
      stable_next[i]   = (age_eff[i] >= {1'b0, cfg.debounce_ms}) ?
                         last_raw_next[i] : stable[i];
      age_sum[i]       = {1'b0, age_eff[i]} + (AW+1)'(cfg.poll_step_ms);
      age_next[i]      = age_sum[i][AW] ? '1 : age_sum[i][AW-1:0];
    end
  end

  // Rising edges of the debounced buttons (index 0 and 2)
  assign button_prev_next = {stable_next[2], stable_next[0]};

  // Blink half period
  assign blink_wrap       = (blink_timer >= cfg.blink_half_ms);
  assign blink_state_next = blink_state ^ blink_wrap;
  assign blink_eff        = blink_wrap ? '0 : blink_timer;
  assign blink_sum        = {1'b0, blink_eff} + (BW+1)'(cfg.poll_step_ms);
  assign blink_timer_next = blink_sum[BW] ? '1 : blink_sum[BW-1:0];

  assign cond.closed_one = stable_next[1];
  assign cond.closed_two = stable_next[3];
  assign cond.edge_one   = stable_next[0] & ~button_prev[0];
  assign cond.edge_two   = stable_next[2] & ~button_prev[1];
  assign cond.blink      = blink_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable      <= '0;
      last_raw    <= '0;
      for (int i = 0; i < 4; i++) age[i] <= '0;
      button_prev <= '0;
      blink_state <= 1'b0;
      blink_timer <= '0;
    end else if (step) begin
      stable      <= stable_next;
      last_raw    <= last_raw_next;
      for (int i = 0; i < 4; i++) age[i] <= age_next[i];
      button_prev <= button_prev_next;
      blink_state <= blink_state_next;
      blink_timer <= blink_timer_next;
    end
  end

endmodule

// ===== rtl/twic_phase.sv =====
// ----------------------------------------------------------------------------
// twic_phase
// Five-phase interlock sequencer with phase timer and output drive.
// ----------------------------------------------------------------------------
module twic_phase (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  twic_pkg::cfg_t    cfg,
  input  twic_pkg::cond_t   cond,
  output twic_pkg::result_t res
);

  localparam int unsigned TW = twic_pkg::TIMER_W;

  twic_pkg::phase_e phase, ph;
  twic_pkg::win_e   active, act;
  twic_pkg::drive_t drive, d;
  logic [TW-1:0]    timer, tmr, timer_next;
  logic [TW:0]      timer_sum;
  logic             auth_one, auth_two, anomaly, one, closed;

  assign auth_one = (active == twic_pkg::WIN_ONE) &&
                    (phase == twic_pkg::PH_UNLOCKED || phase == twic_pkg::PH_OPEN);
  assign auth_two = (active == twic_pkg::WIN_TWO) &&
                    (phase == twic_pkg::PH_UNLOCKED || phase == twic_pkg::PH_OPEN);
  assign anomaly  = (!cond.closed_one && !auth_one) || (!cond.closed_two && !auth_two);

  // Window the unlocked / open phases are working on
  assign one    = (active == twic_pkg::WIN_ONE);
  assign closed = one ? cond.closed_one : cond.closed_two;

  // Phase step
  always_comb begin
    ph  = phase;
    act = active;
    tmr = timer;
    d   = drive;
    // unauthorized open window overrides everything
    if (anomaly && phase != twic_pkg::PH_ALARM) begin
      ph  = twic_pkg::PH_ALARM;
      act = twic_pkg::WIN_VACANT;
      tmr = '0;
    end
    case (ph)
      twic_pkg::PH_READY: begin
        d.lock_one  = 1'b1;
        d.lock_two  = 1'b1;
        d.green_one = 1'b1;
        d.red_one   = 1'b0;
        d.green_two = 1'b1;
        d.red_two   = 1'b0;
        if (cond.edge_one) begin
          act        = twic_pkg::WIN_ONE;
          d.lock_one = 1'b0;
          ph         = twic_pkg::PH_UNLOCKED;
          tmr        = '0;
        end else if (cond.edge_two) begin
          act        = twic_pkg::WIN_TWO;
          d.lock_two = 1'b0;
          ph         = twic_pkg::PH_UNLOCKED;
          tmr        = '0;
        end
      end
      twic_pkg::PH_UNLOCKED: begin
        d.green_one = one & cond.blink;
        d.red_one   = ~one;
        d.green_two = ~one & cond.blink;
        d.red_two   = one;
        if (!closed) begin
          if (one) d.lock_one = 1'b1;
          else     d.lock_two = 1'b1;
          ph  = twic_pkg::PH_OPEN;
          tmr = '0;
        end else if (tmr >= TW'(cfg.lock_release_ms)) begin
          if (one) d.lock_one = 1'b1;
          else     d.lock_two = 1'b1;
          act = twic_pkg::WIN_VACANT;
          ph  = twic_pkg::PH_READY;
          tmr = '0;
        end
      end
      twic_pkg::PH_OPEN: begin
        d.green_one = one & cond.blink;
        d.red_one   = ~one;
        d.green_two = ~one & cond.blink;
        d.red_two   = one;
        if (closed) begin
          ph  = twic_pkg::PH_REGEN;
          tmr = '0;
        end
      end
      twic_pkg::PH_REGEN: begin
        d.lock_one  = 1'b1;
        d.lock_two  = 1'b1;
        d.green_one = 1'b0;
        d.red_one   = 1'b1;
        d.green_two = 1'b0;
        d.red_two   = 1'b1;
        if (tmr >= cfg.regen_ms) begin
          act = twic_pkg::WIN_VACANT;
          ph  = twic_pkg::PH_READY;
          tmr = '0;
        end
      end
      twic_pkg::PH_ALARM: begin
        d.lock_one  = 1'b1;
        d.lock_two  = 1'b1;
        d.green_one = cond.blink;
        d.red_one   = ~cond.blink;
        d.green_two = ~cond.blink;
        d.red_two   = cond.blink;
        d.buzzer    = cfg.buzzer_enable & cond.blink;
        if (!anomaly) begin
          d.buzzer = 1'b0;
          ph       = twic_pkg::PH_REGEN;
          tmr      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Saturating phase timer
  assign timer_sum  = {1'b0, tmr} + (TW+1)'(cfg.poll_step_ms);
  assign timer_next = timer_sum[TW] ? '1 : timer_sum[TW-1:0];

  assign res.phase      = ph;
  assign res.active     = act;
  assign res.drive      = d;
  assign res.closed_one = cond.closed_one;
  assign res.closed_two = cond.closed_two;
  assign res.elapsed    = tmr;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= twic_pkg::PH_REGEN;
      active <= twic_pkg::WIN_VACANT;
      timer  <= '0;
      drive  <= twic_pkg::DRIVE_RST;
    end else if (step) begin
      phase  <= ph;
      active <= act;
      timer  <= timer_next;
      drive  <= d;
    end
  end

endmodule

// ===== rtl/two_window_interlock_controller_unit.sv =====
// ----------------------------------------------------------------------------
// two_window_interlock_controller_unit
// Usage:
//   Input channel (in_valid / in_stall): one poll word per accepted cycle,
//   carrying the four raw levels; each poll advances time by the poll step.
//   Output channel (out_valid / out_stall): one result word per poll.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; out-of-range timing values are dropped, unknown indexes too.
//   Write config only while no poll is in flight.
// Latency: the result for a poll appears on the cycle after acceptance.
// Throughput: one poll per cycle unless out_stall holds the output word; the whole
//   poll (debounce, edge, blink, phase step) is combinational and lands in the output register.
// Stall: while the output word is held by out_stall, in_stall is raised;
//   a poll is taken in the same cycle the waiting word leaves.
// Reset: synchronous on rst; phase starts in regeneration, both locks
//   engaged, lamps and buzzer off, all timers at zero.
// ----------------------------------------------------------------------------
`include "two_window_interlock_controller_unit_defines.svh"

module two_window_interlock_controller_unit (
  input  logic                             clk,
  input  logic                             rst,
  // Poll input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             button_one_raw,
  input  logic                             closed_one_raw,
  input  logic                             button_two_raw,
  input  logic                             closed_two_raw,
  // Result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       phase_now,
  output logic [1:0]                       active_window,
  output logic                             lock_one_engaged,
  output logic                             lock_two_engaged,
  output logic                             green_one,
  output logic                             red_one,
  output logic                             green_two,
  output logic                             red_two,
  output logic                             buzzer_on,
  output logic                             window_one_closed,
  output logic                             window_two_closed,
  output logic [twic_pkg::TIMER_W-1:0]     phase_elapsed_ms,
  // Configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [twic_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [twic_pkg::CFG_DATA_W-1:0]  cfg_data
);

  twic_pkg::cfg_t    cfg;
  twic_pkg::cond_t   cond;
  twic_pkg::result_t res;
  twic_pkg::result_t out_word;
  logic              step;
  logic              out_valid_next;

  assign cfg_ready = 1'b1;

  // Take a poll unless a finished word is still held
  assign in_stall = out_valid & out_stall;
  assign step     = in_valid & ~in_stall;

  twic_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  twic_debounce u_debounce (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .raw  ({closed_two_raw, button_two_raw, closed_one_raw, button_one_raw}),
    .cond (cond)
  );

  twic_phase u_phase (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .cond (cond),
    .res  (res)
  );

  // Output register
  always_comb begin
    out_valid_next = out_valid;
    if (step)            out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= res;
    end
  end

  assign phase_now         = out_word.phase;
  assign active_window     = out_word.active;
  assign lock_one_engaged  = out_word.drive.lock_one;
  assign lock_two_engaged  = out_word.drive.lock_two;
  assign green_one         = out_word.drive.green_one;
  assign red_one           = out_word.drive.red_one;
  assign green_two         = out_word.drive.green_two;
  assign red_two           = out_word.drive.red_two;
  assign buzzer_on         = out_word.drive.buzzer;
  assign window_one_closed = out_word.closed_one;
  assign window_two_closed = out_word.closed_two;
  assign phase_elapsed_ms  = out_word.elapsed;

  // Checks
  `TWIC_ASSERT_NEXT(a_step_gives_word, step, out_valid, "accepted poll produced no result word")
  `TWIC_ASSERT_IMP(a_held_word_blocks, out_valid && out_stall, in_stall, "poll taken over held word")
  `TWIC_ASSERT_IMP(a_alarm_locked, out_valid && phase_now == twic_pkg::PH_ALARM, lock_one_engaged && lock_two_engaged, "alarm with a lock released")
  `TWIC_ASSERT_IMP(a_ready_no_window, out_valid && phase_now == twic_pkg::PH_READY, active_window == twic_pkg::WIN_VACANT, "ready phase with an active window")
  `TWIC_ASSERT_IMP(a_buzzer_only_alarm, out_valid && buzzer_on, phase_now == twic_pkg::PH_ALARM, "buzzer on outside alarm")

endmodule
